// File: hw/rtl/pipp_pkg.sv
// Shared types, ray bit positions and the crossing decision for the polygon parity unit.
package pipp_pkg;

    // Ray bit positions inside the parity vector
    localparam int RAY_COUNT = 4;
    localparam int RAY_RIGHT = 0;
    localparam int RAY_LEFT  = 1;
    localparam int RAY_UP    = 2;
    localparam int RAY_DOWN  = 3;

    // Per-edge qualifiers produced next to the products
    typedef struct packed {
        logic h_en;    // edge counts for the horizontal rays
        logic v_en;    // edge counts for the vertical rays
        logic dy_neg;  // edge runs downwards
        logic dx_neg;  // edge runs leftwards
    } t_edge_flags;

    typedef logic [RAY_COUNT-1:0] t_rays;

    // Which rays an edge crosses, given A<=B (le) and A>=B (ge), where
    // A = (px-x1)*dy and B = dx*(py-y1). The vertical test compares B with A,
    // so its sense is the mirror of the horizontal one.
    function automatic t_rays ray_toggles(t_edge_flags f, logic le, logic ge);
        t_rays t;
        t = '0;
        t[RAY_RIGHT] = f.h_en & (f.dy_neg ? ge : le);
        t[RAY_LEFT]  = f.h_en & (f.dy_neg ? le : ge);
        t[RAY_UP]    = f.v_en & (f.dx_neg ? le : ge);
        t[RAY_DOWN]  = f.v_en & (f.dx_neg ? ge : le);
        return t;
    endfunction

endpackage

// File: hw/rtl/point_in_polygon_parity_unit.sv
// Top level of the point-in-polygon parity unit: four-ray crossing parity over a vertex stream.
//
//  Channel | Valid        | Ready        | Payload
//  --------+--------------+--------------+-------------------------------------------------
//  vertex  | i_in_valid   | o_in_ready   | i_point_x/y, i_vertex_x/y, i_first/last_vertex
//  result  | o_out_valid  | i_out_ready  | o_inside_res, o_right/left/up/down_odd
//
// One vertex item per cycle while o_in_ready is high. Three register stages: input register,
// product register (the edge products) and result register; a last vertex shows its result once it
// has passed through all three in order. Items that are not last leave no result and never wait for the output.
// Reset (i_rst_n low, synchronous) empties all stages, zeroes start, prior and parity.
// A stalled result blocks the product register only when it holds a last item; the input register can still fill.
module point_in_polygon_parity_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic                          i_first_vertex,
    input  logic                          i_last_vertex,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_inside_res,
    output logic                          o_right_odd,
    output logic                          o_left_odd,
    output logic                          o_up_odd,
    output logic                          o_down_odd
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    // Input register
    logic                          r_s1_valid, r_s1_first, r_s1_last;
    logic signed [COORD_WIDTH-1:0] r_s1_px, r_s1_py, r_s1_vx, r_s1_vy;

    // Polygon state
    logic signed [COORD_WIDTH-1:0] r_start_x, r_start_y, r_prior_x, r_prior_y;
    logic signed [COORD_WIDTH-1:0] n_start_x, n_start_y;
    pipp_pkg::t_rays               r_parity, n_parity;

    // Product register
    logic                   r_s2_valid, r_s2_first, r_s2_last;
    pipp_pkg::t_edge_flags  r_s2_flags1, r_s2_flags2, flags1, flags2;
    logic signed [PW-1:0]   r_s2_a1, r_s2_b1, r_s2_a2, r_s2_b2;
    logic signed [PW-1:0]   prod_a1, prod_b1, prod_a2, prod_b2;

    // Result register
    logic                   r_out_valid;
    pipp_pkg::t_rays        r_out_rays;

    logic s1_go, s2_go, s2_free;
    pipp_pkg::t_rays toggles1, toggles2;

    // Stage flow: a non-last item never needs the result register
    assign s2_go      = r_s2_valid && (!r_s2_last || !r_out_valid || i_out_ready);
    assign s2_free    = !r_s2_valid || s2_go;
    assign s1_go      = r_s1_valid && s2_free;
    assign o_in_ready = !r_s1_valid || s1_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_s1_px    <= i_point_x;
            r_s1_py    <= i_point_y;
            r_s1_vx    <= i_vertex_x;
            r_s1_vy    <= i_vertex_y;
            r_s1_first <= i_first_vertex;
            r_s1_last  <= i_last_vertex;
        end
    end

    // A first vertex becomes the start point before the closing edge is formed
    assign n_start_x = r_s1_first ? r_s1_vx : r_start_x;
    assign n_start_y = r_s1_first ? r_s1_vy : r_start_y;

    // Edge from the prior vertex
    pipp_edge_terms #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prior (
        .i_edge_en (!r_s1_first),
        .i_x1      (r_prior_x),
        .i_y1      (r_prior_y),
        .i_x2      (r_s1_vx),
        .i_y2      (r_s1_vy),
        .i_px      (r_s1_px),
        .i_py      (r_s1_py),
        .o_flags   (flags1),
        .o_prod_a  (prod_a1),
        .o_prod_b  (prod_b1)
    );

    // Closing edge back to the start vertex
    pipp_edge_terms #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
        .i_edge_en (r_s1_last),
        .i_x1      (r_s1_vx),
        .i_y1      (r_s1_vy),
        .i_x2      (n_start_x),
        .i_y2      (n_start_y),
        .i_px      (r_s1_px),
        .i_py      (r_s1_py),
        .o_flags   (flags2),
        .o_prod_a  (prod_a2),
        .o_prod_b  (prod_b2)
    );

    // Start/prior vertex update and product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_prior_x  <= '0;
            r_prior_y  <= '0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_go) begin
                r_start_x <= n_start_x;
                r_start_y <= n_start_y;
                r_prior_x <= r_s1_vx;
                r_prior_y <= r_s1_vy;
            end
        end
        if (s1_go) begin
            r_s2_first  <= r_s1_first;
            r_s2_last   <= r_s1_last;
            r_s2_flags1 <= flags1;
            r_s2_flags2 <= flags2;
            r_s2_a1     <= prod_a1;
            r_s2_b1     <= prod_b1;
            r_s2_a2     <= prod_a2;
            r_s2_b2     <= prod_b2;
        end
    end

    // Compare the products and fold the crossings into the parity
    assign toggles1 = pipp_pkg::ray_toggles(r_s2_flags1, r_s2_a1 <= r_s2_b1, r_s2_a1 >= r_s2_b1);
    assign toggles2 = pipp_pkg::ray_toggles(r_s2_flags2, r_s2_a2 <= r_s2_b2, r_s2_a2 >= r_s2_b2);
    assign n_parity = (r_s2_first ? '0 : r_parity) ^ toggles1 ^ toggles2;

    // Parity state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_go) begin
                r_parity <= r_s2_last ? '0 : n_parity;
            end
            if (s2_go && r_s2_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s2_go && r_s2_last) begin
            r_out_rays <= n_parity;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = |r_out_rays;
    assign o_right_odd  = r_out_rays[pipp_pkg::RAY_RIGHT];
    assign o_left_odd   = r_out_rays[pipp_pkg::RAY_LEFT];
    assign o_up_odd     = r_out_rays[pipp_pkg::RAY_UP];
    assign o_down_odd   = r_out_rays[pipp_pkg::RAY_DOWN];

    // Parity starts afresh after every result
    a_parity_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && r_s2_last) |=> (r_parity == '0))
        else $error("parity not cleared after result");

    // A first vertex is captured as the start point
    a_start_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_first) |=> (r_start_x == $past(r_s1_vx) && r_start_y == $past(r_s1_vy)))
        else $error("start vertex not captured");

    // A last item behind a stalled result stays put
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_last && r_out_valid && !i_out_ready) |=> r_s2_valid)
        else $error("last item lost behind stalled result");

    // An empty input register always takes an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stalled while input register empty");

endmodule

// File: hw/rtl/pipp_edge_terms.sv
// Edge set-up: differences, range qualifiers and the two exact cross products of one edge.
module pipp_edge_terms #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_edge_en,
    input  logic signed [COORD_WIDTH-1:0]     i_x1,
    input  logic signed [COORD_WIDTH-1:0]     i_y1,
    input  logic signed [COORD_WIDTH-1:0]     i_x2,
    input  logic signed [COORD_WIDTH-1:0]     i_y2,
    input  logic signed [COORD_WIDTH-1:0]     i_px,
    input  logic signed [COORD_WIDTH-1:0]     i_py,
    output pipp_pkg::t_edge_flags             o_flags,
    output logic signed [2*COORD_WIDTH+1:0]   o_prod_a,
    output logic signed [2*COORD_WIDTH+1:0]   o_prod_b
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx, dy, ax, ay;
    logic                 y_in_span, x_in_span;

    // Differences one bit wider than the coordinates, so they never wrap
    assign dx = DW'(i_x2) - DW'(i_x1);
    assign dy = DW'(i_y2) - DW'(i_y1);
    assign ax = DW'(i_px) - DW'(i_x1);
    assign ay = DW'(i_py) - DW'(i_y1);

    // Inclusive span checks on both ends
    assign y_in_span = ((i_y1 <= i_py) && (i_py <= i_y2)) || ((i_y2 <= i_py) && (i_py <= i_y1));
    assign x_in_span = ((i_x1 <= i_px) && (i_px <= i_x2)) || ((i_x2 <= i_px) && (i_px <= i_x1));

    always_comb begin
        o_flags        = '0;
        o_flags.h_en   = i_edge_en && (dy != '0) && y_in_span;
        o_flags.v_en   = i_edge_en && (dx != '0) && x_in_span;
        o_flags.dy_neg = dy[DW-1];
        o_flags.dx_neg = dx[DW-1];
    end

    // A = (px-x1)*dy, B = dx*(py-y1); the vertical test reuses both
    assign o_prod_a = PW'(ax) * PW'(dy);
    assign o_prod_b = PW'(dx) * PW'(ay);

endmodule
